@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers included by chacha_stream_xor_core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/ccsx_pkg.sv @@
// ----------------------------------------------------------------------------
// ccsx_pkg
// shared types and constants for the chacha stream xor core
// ----------------------------------------------------------------------------
package ccsx_pkg;

    // "expand 32-byte k" and "expand 16-byte k"
    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;
    localparam logic [31:0] TAU_1   = 32'h3120646e;
    localparam logic [31:0] TAU_2   = 32'h79622d36;

    localparam int ROT_A = 16;
    localparam int ROT_B = 12;
    localparam int ROT_C = 8;
    localparam int ROT_D = 7;

    localparam int NUM_WORDS = 16;

    // configuration register indexes
    localparam logic [2:0] CFG_KEY_0     = 3'd0;
    localparam logic [2:0] CFG_KEY_1     = 3'd1;
    localparam logic [2:0] CFG_KEY_2     = 3'd2;
    localparam logic [2:0] CFG_KEY_3     = 3'd3;
    localparam logic [2:0] CFG_KEY_256   = 3'd4;
    localparam logic [2:0] CFG_NONCE     = 3'd5;
    localparam logic [2:0] CFG_START_CTR = 3'd6;
    localparam logic [2:0] CFG_ROUNDS    = 3'd7;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_quad;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

endpackage

@@ rtl/chacha_stream_xor_core.sv @@
// ----------------------------------------------------------------------------
// chacha_stream_xor_core: xors 8-byte words with chacha keystream
// first word of a 64-byte block: round pairs, one quarter-round per cycle in a
// shared unit, then feed-forward add, then output; other words go to output.
// input stalls while busy; synchronous active-low reset, config to defaults
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chacha_stream_xor_core import ccsx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_data_in,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_data_out,
    output logic [3:0]  o_byte_count_out,
    output logic        o_last_out
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ROUND = 2'd1;
    localparam logic [1:0] S_FEED  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [63:0] r_key0, r_key1, r_key2, r_key3, r_nonce, r_start;
    logic        r_k256;
    logic [3:0]  r_rounds;

    logic [1:0]  r_state, n_state;
    logic [2:0]  r_qr, n_qr;
    logic [3:0]  r_pair, n_pair;
    logic [3:0]  r_pairs;
    logic [63:0] r_ctr, n_ctr;
    logic [2:0]  r_pos, n_pos;
    logic        r_msg_start, n_msg_start;
    logic        r_ov, n_ov;

    logic [31:0] r_x   [NUM_WORDS];
    logic [31:0] r_bin [NUM_WORDS];
    logic [63:0] r_data;
    logic [3:0]  r_cnt;
    logic        r_last;
    logic [63:0] r_dout;
    logic [3:0]  r_cout;
    logic        r_lout;

    logic        in_acc, out_load, need_blk;
    logic [2:0]  eff_pos;
    logic [63:0] eff_ctr;
    logic [63:0] hk0, hk1;
    logic [3:0]  eff_cnt;
    logic [31:0] w_bin [NUM_WORDS];
    logic [31:0] w_qr  [NUM_WORDS];
    logic [31:0] w_rot [NUM_WORDS];
    t_quad       q_in, q_out;
    logic [63:0] ks, mask;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0   <= '0;
            r_key1   <= '0;
            r_key2   <= '0;
            r_key3   <= '0;
            r_k256   <= 1'b1;
            r_nonce  <= '0;
            r_start  <= '0;
            r_rounds <= 4'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_0:     r_key0   <= i_cfg_data;
                CFG_KEY_1:     r_key1   <= i_cfg_data;
                CFG_KEY_2:     r_key2   <= i_cfg_data;
                CFG_KEY_3:     r_key3   <= i_cfg_data;
                CFG_KEY_256:   r_k256   <= i_cfg_data[0];
                CFG_NONCE:     r_nonce  <= i_cfg_data;
                CFG_START_CTR: r_start  <= i_cfg_data;
                CFG_ROUNDS:    r_rounds <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ---------------- block input ----------------
    always_comb begin
        in_acc   = i_valid && (r_state == S_IDLE);
        out_load = (r_state == S_OUT) && (!r_ov || !i_stall);
        eff_pos  = r_msg_start ? 3'd0 : r_pos;
        eff_ctr  = r_msg_start ? r_start : r_ctr;
        need_blk = (eff_pos == 3'd0);
        hk0      = r_k256 ? r_key2 : r_key0;
        hk1      = r_k256 ? r_key3 : r_key1;

        w_bin[0]  = SIGMA_0;
        w_bin[1]  = r_k256 ? SIGMA_1 : TAU_1;
        w_bin[2]  = r_k256 ? SIGMA_2 : TAU_2;
        w_bin[3]  = SIGMA_3;
        w_bin[4]  = r_key0[31:0];
        w_bin[5]  = r_key0[63:32];
        w_bin[6]  = r_key1[31:0];
        w_bin[7]  = r_key1[63:32];
        w_bin[8]  = hk0[31:0];
        w_bin[9]  = hk0[63:32];
        w_bin[10] = hk1[31:0];
        w_bin[11] = hk1[63:32];
        w_bin[12] = eff_ctr[31:0];
        w_bin[13] = eff_ctr[63:32];
        w_bin[14] = r_nonce[31:0];
        w_bin[15] = r_nonce[63:32];

        // count only matters on the last word, bad values read as a full word
        if (i_last_in && (i_byte_count != 4'd0) && (i_byte_count < 4'd8)) begin
            eff_cnt = i_byte_count;
        end else begin
            eff_cnt = 4'd8;
        end
    end

    // ---------------- round datapath ----------------
    // rows rotate left one word after every quarter-round, so column k and
    // diagonal k always sit at the fixed column or diagonal view
    always_comb begin
        if (r_qr[2]) begin
            q_in = '{a: r_x[0], b: r_x[5], c: r_x[10], d: r_x[15]};
        end else begin
            q_in = '{a: r_x[0], b: r_x[4], c: r_x[8], d: r_x[12]};
        end
    end

    ccsx_qround u_qround (
        .i_quad (q_in),
        .o_quad (q_out)
    );

    always_comb begin
        for (int i = 0; i < NUM_WORDS; i++) begin
            w_qr[i] = r_x[i];
        end
        w_qr[0] = q_out.a;
        if (r_qr[2]) begin
            w_qr[5]  = q_out.b;
            w_qr[10] = q_out.c;
            w_qr[15] = q_out.d;
        end else begin
            w_qr[4]  = q_out.b;
            w_qr[8]  = q_out.c;
            w_qr[12] = q_out.d;
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                w_rot[4 * r + c] = w_qr[4 * r + ((c + 1) % 4)];
            end
        end
    end

    // ---------------- output word ----------------
    always_comb begin
        ks = {r_x[1], r_x[0]};
        for (int b = 0; b < 8; b++) begin
            mask[8 * b +: 8] = (4'(b) < r_cnt) ? 8'hff : 8'h00;
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_qr        = r_qr;
        n_pair      = r_pair;
        n_ctr       = r_ctr;
        n_pos       = r_pos;
        n_msg_start = r_msg_start;
        n_ov        = r_ov;

        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_qr   = '0;
                    n_pair = '0;
                    if (need_blk) begin
                        n_ctr   = eff_ctr + 64'd1;
                        n_state = (r_rounds == 4'd0) ? S_FEED : S_ROUND;
                    end else begin
                        n_ctr   = eff_ctr;
                        n_state = S_OUT;
                    end
                    if (i_last_in) begin
                        n_msg_start = 1'b1;
                        n_pos       = '0;
                    end else begin
                        n_msg_start = 1'b0;
                        n_pos       = eff_pos + 3'd1;
                    end
                end
            end
            S_ROUND: begin
                n_qr = r_qr + 3'd1;
                if (r_qr == 3'd7) begin
                    n_pair = r_pair + 4'd1;
                    if ((r_pair + 4'd1) == r_pairs) begin
                        n_state = S_FEED;
                    end
                end
            end
            S_FEED: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_qr        <= '0;
            r_pair      <= '0;
            r_ctr       <= '0;
            r_pos       <= '0;
            r_msg_start <= 1'b1;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_qr        <= n_qr;
            r_pair      <= n_pair;
            r_ctr       <= n_ctr;
            r_pos       <= n_pos;
            r_msg_start <= n_msg_start;
            r_ov        <= n_ov;
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_data <= i_data_in;
            r_cnt  <= eff_cnt;
            r_last <= i_last_in;
            if (need_blk) begin
                r_pairs <= r_rounds;
                for (int i = 0; i < NUM_WORDS; i++) begin
                    r_x[i]   <= w_bin[i];
                    r_bin[i] <= w_bin[i];
                end
            end
        end
        if (r_state == S_ROUND) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_x[i] <= w_rot[i];
            end
        end
        if (r_state == S_FEED) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_x[i] <= r_x[i] + r_bin[i];
            end
        end
        if (out_load) begin
            r_dout <= (r_data ^ ks) & mask;
            r_cout <= r_cnt;
            r_lout <= r_last;
            // next keystream word moves to the front
            for (int i = 0; i < NUM_WORDS - 2; i++) begin
                r_x[i] <= r_x[i + 2];
            end
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_ov;
    assign o_data_out       = r_dout;
    assign o_byte_count_out = r_cout;
    assign o_last_out       = r_lout;

    `ASSERT_IMPL(a_pair_range, i_clk, i_rst_n, (r_state == S_ROUND), (r_pair < r_pairs))
    `ASSERT_NEXT(a_feed_to_out, i_clk, i_rst_n, (r_state == S_FEED), (r_state == S_OUT))
    `ASSERT_NEXT(a_block_start, i_clk, i_rst_n, (in_acc && need_blk), ((r_state == S_ROUND) || (r_state == S_FEED)))

endmodule

@@ rtl/ccsx_qround.sv @@
// ----------------------------------------------------------------------------
// ccsx_qround
// one chacha quarter-round on four 32-bit words
// ----------------------------------------------------------------------------
module ccsx_qround import ccsx_pkg::*; (
    input  t_quad i_quad,
    output t_quad o_quad
);

    logic [31:0] a1, d1, c1, b1, a2, d2, c2, b2;

    always_comb begin
        a1 = i_quad.a + i_quad.b;
        d1 = rotl(i_quad.d ^ a1, ROT_A);
        c1 = i_quad.c + d1;
        b1 = rotl(i_quad.b ^ c1, ROT_B);
        a2 = a1 + b1;
        d2 = rotl(d1 ^ a2, ROT_C);
        c2 = c1 + d2;
        b2 = rotl(b1 ^ c2, ROT_D);
        o_quad = '{a: a2, b: b2, c: c2, d: d2};
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for chacha_stream_xor_core
// sends messages of 8-byte words through the core under changing key, key size,
// nonce, start counter and round settings. a software copy of the cipher
// predicts every output word, and each output is compared field by field.
// idling and stalling on both sides vary from phase to phase
// ----------------------------------------------------------------------------

typedef struct {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
} t_xor_word;

class cipher_scoreboard;
    logic [63:0] key [4];
    logic        key_256;
    logic [63:0] nonce;
    logic [63:0] start_ctr;
    logic [3:0]  rounds;
    logic [63:0] block_ctr;
    logic [2:0]  word_pos;
    logic        msg_start;
    logic [31:0] state_in [16];
    logic [31:0] mix [16];
    logic [31:0] keystream [16];
    t_xor_word   expected_words [$];
    int          fails;

    function new();
        for (int i = 0; i < 4; i++)
            key[i] = 64'd0;
        key_256   = 1'b1;
        nonce     = 64'd0;
        start_ctr = 64'd0;
        rounds    = 4'd10;
        block_ctr = 64'd0;
        word_pos  = 3'd0;
        msg_start = 1'b1;
        fails     = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] value);
        case (idx)
            ccsx_pkg::CFG_KEY_0:     key[0] = value;
            ccsx_pkg::CFG_KEY_1:     key[1] = value;
            ccsx_pkg::CFG_KEY_2:     key[2] = value;
            ccsx_pkg::CFG_KEY_3:     key[3] = value;
            ccsx_pkg::CFG_KEY_256:   key_256 = value[0];
            ccsx_pkg::CFG_NONCE:     nonce = value;
            ccsx_pkg::CFG_START_CTR: start_ctr = value;
            ccsx_pkg::CFG_ROUNDS:    rounds = value[3:0];
            default: ;
        endcase
    endfunction

    function logic [31:0] rol32(logic [31:0] v, int s);
        logic [63:0] t;
        t = {v, v} << s;
        return t[63:32];
    endfunction

    function void quarter(int a, int b, int c, int d);
        mix[a] = mix[a] + mix[b]; mix[d] = rol32(mix[d] ^ mix[a], 16);
        mix[c] = mix[c] + mix[d]; mix[b] = rol32(mix[b] ^ mix[c], 12);
        mix[a] = mix[a] + mix[b]; mix[d] = rol32(mix[d] ^ mix[a], 8);
        mix[c] = mix[c] + mix[d]; mix[b] = rol32(mix[b] ^ mix[c], 7);
    endfunction

    // key, nonce, key size and rounds are taken fresh for every block
    function void build_block();
        logic [63:0] hk0;
        logic [63:0] hk1;
        hk0 = key_256 ? key[2] : key[0];
        hk1 = key_256 ? key[3] : key[1];
        state_in[0]  = ccsx_pkg::SIGMA_0;
        state_in[1]  = key_256 ? ccsx_pkg::SIGMA_1 : ccsx_pkg::TAU_1;
        state_in[2]  = key_256 ? ccsx_pkg::SIGMA_2 : ccsx_pkg::TAU_2;
        state_in[3]  = ccsx_pkg::SIGMA_3;
        state_in[4]  = key[0][31:0];
        state_in[5]  = key[0][63:32];
        state_in[6]  = key[1][31:0];
        state_in[7]  = key[1][63:32];
        state_in[8]  = hk0[31:0];
        state_in[9]  = hk0[63:32];
        state_in[10] = hk1[31:0];
        state_in[11] = hk1[63:32];
        state_in[12] = block_ctr[31:0];
        state_in[13] = block_ctr[63:32];
        state_in[14] = nonce[31:0];
        state_in[15] = nonce[63:32];
        mix = state_in;
        for (int r = 0; r < int'(rounds); r++) begin
            quarter(0, 4, 8, 12);
            quarter(1, 5, 9, 13);
            quarter(2, 6, 10, 14);
            quarter(3, 7, 11, 15);
            quarter(0, 5, 10, 15);
            quarter(1, 6, 11, 12);
            quarter(2, 7, 8, 13);
            quarter(3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++)
            keystream[i] = mix[i] + state_in[i];
    endfunction

    function void take_word(logic [63:0] data, logic [3:0] count, logic last);
        t_xor_word   want;
        int          p;
        logic [63:0] ks;
        if (msg_start) begin
            block_ctr = start_ctr;
            word_pos  = 3'd0;
        end
        p = int'(word_pos);
        if (p == 0) begin
            build_block();
            block_ctr = block_ctr + 64'd1;
        end
        ks = {keystream[2 * p + 1], keystream[2 * p]};
        want.data  = data ^ ks;
        want.count = (!last || count == 4'd0 || count > 4'd8) ? 4'd8 : count;
        want.last  = last;
        if (want.count < 4'd8)
            want.data &= (64'd1 << (8 * int'(want.count))) - 64'd1;
        expected_words.push_back(want);
        if (last) begin
            msg_start = 1'b1;
            word_pos  = 3'd0;
        end else begin
            msg_start = 1'b0;
            word_pos  = word_pos + 3'd1;
        end
    endfunction

    function void flag(string why, t_xor_word want, t_xor_word got);
        if (fails < 10)
            $display("%0t %s: expected data %h count %0d last %0b, got data %h count %0d last %0b",
                     $time, why, want.data, want.count, want.last,
                     got.data, got.count, got.last);
        fails++;
    endfunction

    function void check_word(logic [63:0] data, logic [3:0] count, logic last);
        t_xor_word want;
        t_xor_word got;
        got.data  = data;
        got.count = count;
        got.last  = last;
        if (expected_words.size() == 0) begin
            want = '{default: '0};
            flag("output word with none expected", want, got);
        end else begin
            want = expected_words.pop_front();
            if (want.data !== got.data || want.count !== got.count ||
                want.last !== got.last)
                flag("output word mismatch", want, got);
        end
    endfunction

    function int pending();
        return expected_words.size();
    endfunction
endclass

module tb;
    import ccsx_pkg::*;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    localparam int N_RANDOM     = 1600;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 140;   // longer than the slowest block, 15 round pairs

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_data_in;
    logic [3:0]  i_byte_count;
    logic        i_last_in;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_data_out;
    logic [3:0]  o_byte_count_out;
    logic        o_last_out;

    cipher_scoreboard sb;
    int idle_pct  = 0;
    int stall_pct = 0;
    int cycle_count = 0;

    chacha_stream_xor_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_in        (i_data_in),
        .i_byte_count     (i_byte_count),
        .i_last_in        (i_last_in),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_data_out       (o_data_out),
        .o_byte_count_out (o_byte_count_out),
        .o_last_out       (o_last_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // output side: check accepted words, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_word(o_data_out, o_byte_count_out, o_last_out);
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_wide();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin idle_pct = 0;  stall_pct = 0;  end
            IDLE_SEND: begin idle_pct = 79; stall_pct = 0;  end
            IDLE_RECV: begin idle_pct = 0;  stall_pct = 79; end
            default:   begin idle_pct = 32; stall_pct = 32; end
        endcase
    endtask

    task automatic send_word(input logic [63:0] d, input logic [3:0] c, input logic l);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_in    <= d;
        i_byte_count <= c;
        i_last_in    <= l;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sb.take_word(d, c, l);
    endtask

    // caller lowers i_cfg_we after the last write of a batch
    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        sb.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    // let every expected word come out before touching the registers
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        logic [63:0] d;
        logic [63:0] v;
        logic [3:0]  c;
        logic [2:0]  idx;
        int          sent;
        int          left;
        int          phase;
        int          n;

        sb = new();
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= CFG_KEY_0;
        i_cfg_data   <= 64'd0;
        i_valid      <= 1'b0;
        i_data_in    <= 64'd0;
        i_byte_count <= 4'd8;
        i_last_in    <= 1'b0;
        set_idling(IDLE_NONE);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, nine words to cross into a second block;
        // byte counts on non-last words must be ignored
        for (int k = 0; k < 9; k++) begin
            case (k)
                0: d = 64'd0;
                1: d = '1;
                default: d = rand64();
            endcase
            send_word(d, (k == 8) ? 4'd5 : 4'(k * 3), k == 8);
        end
        // single-word messages with odd counts on the last word
        for (int k = 0; k < 5; k++) begin
            case (k)
                0: c = 4'd0;
                1: c = 4'd1;
                2: c = 4'd7;
                3: c = 4'd9;
                default: c = 4'd15;
            endcase
            send_word(rand64(), c, 1'b1);
        end

        // 128-bit key, one round pair, counter wraps inside the message
        settle();
        cfg_write(CFG_KEY_0, '1);
        cfg_write(CFG_KEY_1, rand64());
        cfg_write(CFG_KEY_2, 64'd0);
        cfg_write(CFG_KEY_3, rand64());
        cfg_write(CFG_KEY_256, 64'd0);
        cfg_write(CFG_NONCE, '1);
        cfg_write(CFG_START_CTR, '1);
        cfg_write(CFG_ROUNDS, 64'd1);
        i_cfg_we <= 1'b0;
        for (int k = 0; k < 9; k++)
            send_word(rand64(), 4'd8, k == 8);

        // no round pairs at all, then the largest count the field holds
        settle();
        cfg_write(CFG_ROUNDS, 64'd0);
        i_cfg_we <= 1'b0;
        send_word(rand64(), 4'd8, 1'b1);
        settle();
        cfg_write(CFG_ROUNDS, 64'd15);
        cfg_write(CFG_KEY_256, 64'd1);
        i_cfg_we <= 1'b0;
        send_word(rand64(), 4'd8, 1'b1);

        // random phases; a phase may end inside a message, so register
        // changes also land between blocks of one message
        sent  = 0;
        left  = 0;
        phase = 0;
        while (sent < N_RANDOM) begin
            settle();
            for (int r = 0; r < 8; r++) begin
                idx = 3'(r);
                if (phase == 0 || $urandom_range(0, 1) == 1) begin
                    case (idx)
                        CFG_KEY_256: v = rand64();
                        CFG_START_CTR: begin
                            case ($urandom_range(0, 5))
                                0: v = 64'd0;
                                1: v = '1;
                                2: v = 64'h0000_0000_FFFF_FFFF;
                                3: v = {$urandom, 32'hFFFF_FFFE};
                                4: v = 64'hFFFF_FFFF_FFFF_FFFE;
                                default: v = rand64();
                            endcase
                        end
                        CFG_ROUNDS: begin
                            v = rand64();
                            if ($urandom_range(0, 7) == 0)
                                v[3:0] = 4'($urandom_range(0, 15));
                            else
                                v[3:0] = 4'($urandom_range(1, 10));
                        end
                        default: v = pick_wide();
                    endcase
                    cfg_write(idx, v);
                end
            end
            i_cfg_we <= 1'b0;
            set_idling(t_idle_mode'(phase % 4));
            n = $urandom_range(80, 200);
            for (int k = 0; k < n && sent < N_RANDOM; k++) begin
                if (left == 0)
                    left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
                                                       : $urandom_range(1, 12);
                case ($urandom_range(0, 15))
                    0: d = 64'd0;
                    1: d = '1;
                    default: d = rand64();
                endcase
                if (left == 1 && $urandom_range(0, 3) != 0)
                    c = 4'($urandom_range(1, 8));
                else
                    c = 4'($urandom_range(0, 15));
                send_word(d, c, left == 1);
                left--;
                sent++;
            end
            phase++;
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/ccsx_pkg.sv
rtl/ccsx_qround.sv
rtl/chacha_stream_xor_core.sv
sim/tb.sv
